// ===== src/qvr_pkg.sv =====
`timescale 1ns / 1ps
package qvr_pkg;
  localparam int unsigned CompW   = 16;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned SumW    = 33;
  localparam int unsigned NormW   = 34;
  localparam int unsigned TermW   = 49;
  localparam int unsigned NumW    = 52;
  localparam int unsigned DivD    = 52;
  localparam int unsigned QuotW   = 17;
  localparam int unsigned RemW    = DivD - QuotW;
  localparam int unsigned DvsW    = 34;
  localparam int unsigned InDataW = 112;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned Lanes   = 3;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic [InDataW-1:0]      in_data_t;
  typedef logic [OutDataW-1:0]     out_data_t;
  typedef logic [OutUserW-1:0]     out_user_t;

  localparam logic signed [CompW-1:0] SatMax = 16'sh7FFF;
  localparam logic signed [CompW-1:0] SatMin = 16'sh8000;
endpackage

// ===== src/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled; the 17-step pipelined restoring divider
// (one quotient bit per stage, one divider per axis) sets the pipeline depth.
// The whole pipeline advances together whenever the output register is empty or drained.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are not reset.
module quaternion_vector_rotate (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, 16 bits each from bit 0
  input  qvr_pkg::in_data_t      in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // rot_x [15:0], rot_y [31:16], rot_z [47:32]
  output qvr_pkg::out_data_t     out_tdata,
  // clipped [0], zero_quat [1]
  output qvr_pkg::out_user_t     out_tuser
);
  import qvr_pkg::*;

  localparam int unsigned Steps = QuotW;

  // Global advance: every stage moves when the output register can take a result.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Unpack the input transaction.
  comp_t qw, qx, qy, qz;
  comp_t v_in [Lanes];
  assign qw       = comp_t'(in_tdata[15:0]);
  assign qx       = comp_t'(in_tdata[31:16]);
  assign qy       = comp_t'(in_tdata[47:32]);
  assign qz       = comp_t'(in_tdata[63:48]);
  assign v_in[0]  = comp_t'(in_tdata[79:64]);
  assign v_in[1]  = comp_t'(in_tdata[95:80]);
  assign v_in[2]  = comp_t'(in_tdata[111:96]);

  // Stage 1: all 16x16 products.
  logic                    s1_v_r;
  logic signed [ProdW-1:0] s1_ww_r, s1_xx_r, s1_yy_r, s1_zz_r;
  logic signed [ProdW-1:0] s1_xvx_r, s1_yvy_r, s1_zvz_r;
  logic signed [ProdW-1:0] s1_yvz_r, s1_zvy_r, s1_zvx_r, s1_xvz_r, s1_xvy_r, s1_yvx_r;
  comp_t                   s1_w_r;
  comp_t                   s1_u_r [Lanes];
  comp_t                   s1_vec_r [Lanes];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ww_r  <= qw * qw;
      s1_xx_r  <= qx * qx;
      s1_yy_r  <= qy * qy;
      s1_zz_r  <= qz * qz;
      s1_xvx_r <= qx * v_in[0];
      s1_yvy_r <= qy * v_in[1];
      s1_zvz_r <= qz * v_in[2];
      s1_yvz_r <= qy * v_in[2];
      s1_zvy_r <= qz * v_in[1];
      s1_zvx_r <= qz * v_in[0];
      s1_xvz_r <= qx * v_in[2];
      s1_xvy_r <= qx * v_in[1];
      s1_yvx_r <= qy * v_in[0];
      s1_w_r   <= qw;
      s1_u_r[0] <= qx;
      s1_u_r[1] <= qy;
      s1_u_r[2] <= qz;
      for (int i = 0; i < Lanes; i++) begin
        s1_vec_r[i] <= v_in[i];
      end
    end
  end

  // Stage 2: squared norm, scalar term, dot and cross products.
  logic                    s2_v_r;
  logic [NormW-1:0]        s2_n_r;
  logic signed [SumW-1:0]  s2_s_r, s2_dot_r;
  logic signed [SumW-1:0]  s2_cr_r [Lanes];
  comp_t                   s2_w_r;
  comp_t                   s2_u_r [Lanes];
  comp_t                   s2_vec_r [Lanes];
  logic signed [SumW-1:0]  uu;

  assign uu = SumW'(s1_xx_r) + SumW'(s1_yy_r) + SumW'(s1_zz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n_r     <= NormW'(unsigned'(SumW'(s1_ww_r))) + NormW'(unsigned'(uu));
      s2_s_r     <= SumW'(s1_ww_r) - uu;
      s2_dot_r   <= SumW'(s1_xvx_r) + SumW'(s1_yvy_r) + SumW'(s1_zvz_r);
      s2_cr_r[0] <= SumW'(s1_yvz_r) - SumW'(s1_zvy_r);
      s2_cr_r[1] <= SumW'(s1_zvx_r) - SumW'(s1_xvz_r);
      s2_cr_r[2] <= SumW'(s1_xvy_r) - SumW'(s1_yvx_r);
      s2_w_r     <= s1_w_r;
      for (int i = 0; i < Lanes; i++) begin
        s2_u_r[i]   <= s1_u_r[i];
        s2_vec_r[i] <= s1_vec_r[i];
      end
    end
  end

  // Stage 3: the three product terms of each numerator. Operands are
  // sign-extended to the term width so that the full product is kept.
  logic                    s3_v_r;
  logic [NormW-1:0]        s3_n_r;
  logic signed [TermW-1:0] s3_ta_r [Lanes];
  logic signed [TermW-1:0] s3_tb_r [Lanes];
  logic signed [TermW-1:0] s3_tc_r [Lanes];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n_r <= s2_n_r;
      for (int i = 0; i < Lanes; i++) begin
        s3_ta_r[i] <= TermW'(s2_vec_r[i]) * TermW'(s2_s_r);
        s3_tb_r[i] <= TermW'(s2_u_r[i]) * TermW'(s2_dot_r);
        s3_tc_r[i] <= TermW'(s2_w_r) * TermW'(s2_cr_r[i]);
      end
    end
  end

  // Stage 4: numerators v*s + 2*u*(u.v) + 2*w*(u x v).
  logic                   s4_v_r;
  logic [NormW-1:0]       s4_n_r;
  logic signed [NumW-1:0] s4_num_r [Lanes];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_n_r <= s3_n_r;
      for (int i = 0; i < Lanes; i++) begin
        s4_num_r[i] <= NumW'(s3_ta_r[i]) + (NumW'(s3_tb_r[i]) <<< 1)
                       + (NumW'(s3_tc_r[i]) <<< 1);
      end
    end
  end

  // Divider pipeline. Entry 0 holds the dividend 2*|num| + n split into the
  // initial partial remainder and the low bits still to be shifted in; each
  // following entry has retired one more quotient bit.
  logic             d_v_r    [Steps+1];
  logic             d_zq_r   [Steps+1];
  logic [DvsW-1:0]  d_dv_r   [Steps+1];
  logic [RemW-1:0]  d_rem_r  [Steps+1][Lanes];
  logic [QuotW-1:0] d_low_r  [Steps+1][Lanes];
  logic [QuotW-1:0] d_q_r    [Steps+1][Lanes];
  logic             d_neg_r  [Steps+1][Lanes];

  logic [DivD-1:0]  dividend [Lanes];
  logic [NumW-1:0]  mag      [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag[i]      = s4_num_r[i][NumW-1] ? NumW'(-s4_num_r[i]) : NumW'(s4_num_r[i]);
      dividend[i] = DivD'({mag[i], 1'b0}) + DivD'(s4_n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= Steps; k++) begin
        d_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      d_v_r[0] <= s4_v_r;
      for (int k = 1; k <= Steps; k++) begin
        d_v_r[k] <= d_v_r[k-1];
      end
    end
  end

  logic [RemW-1:0] trial [Steps][Lanes];

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      for (int i = 0; i < Lanes; i++) begin
        trial[k][i] = {d_rem_r[k][i][RemW-2:0], d_low_r[k][i][QuotW-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_zq_r[0] <= (s4_n_r == '0);
      d_dv_r[0] <= DvsW'({s4_n_r[NormW-2:0], 1'b0});
      for (int i = 0; i < Lanes; i++) begin
        d_rem_r[0][i] <= dividend[i][DivD-1:QuotW];
        d_low_r[0][i] <= dividend[i][QuotW-1:0];
        d_q_r[0][i]   <= '0;
        d_neg_r[0][i] <= s4_num_r[i][NumW-1];
      end
      for (int k = 0; k < Steps; k++) begin
        d_zq_r[k+1] <= d_zq_r[k];
        d_dv_r[k+1] <= d_dv_r[k];
        for (int i = 0; i < Lanes; i++) begin
          d_low_r[k+1][i] <= {d_low_r[k][i][QuotW-2:0], 1'b0};
          d_neg_r[k+1][i] <= d_neg_r[k][i];
          if (trial[k][i] >= RemW'(d_dv_r[k])) begin
            d_rem_r[k+1][i] <= trial[k][i] - RemW'(d_dv_r[k]);
            d_q_r[k+1][i]   <= {d_q_r[k][i][QuotW-2:0], 1'b1};
          end else begin
            d_rem_r[k+1][i] <= trial[k][i];
            d_q_r[k+1][i]   <= {d_q_r[k][i][QuotW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output stage: sign, saturation, zero-quaternion override.
  comp_t rot_nxt [Lanes];
  logic  clip_lane [Lanes];
  logic  clip_nxt;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      clip_lane[i] = 1'b0;
      if (d_neg_r[Steps][i]) begin
        if (d_q_r[Steps][i] > QuotW'(32768)) begin
          rot_nxt[i]   = SatMin;
          clip_lane[i] = 1'b1;
        end else begin
          rot_nxt[i] = comp_t'(-d_q_r[Steps][i]);
        end
      end else begin
        if (d_q_r[Steps][i] > QuotW'(32767)) begin
          rot_nxt[i]   = SatMax;
          clip_lane[i] = 1'b1;
        end else begin
          rot_nxt[i] = comp_t'(d_q_r[Steps][i]);
        end
      end
      if (d_zq_r[Steps]) begin
        rot_nxt[i]   = '0;
        clip_lane[i] = 1'b0;
      end
    end
    clip_nxt = clip_lane[0] | clip_lane[1] | clip_lane[2];
  end

  logic      out_v_r;
  out_data_t out_data_r;
  out_user_t out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d_v_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {rot_nxt[2], rot_nxt[1], rot_nxt[0]};
      out_user_r <= {d_zq_r[Steps], clip_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A zero quaternion yields a zero vector and never a clip.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("zero quaternion result not cleared");

  // A clip flag means some component sits at a saturation limit.
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[15:0] == SatMax || out_tdata[15:0] == SatMin ||
      out_tdata[31:16] == SatMax || out_tdata[31:16] == SatMin ||
      out_tdata[47:32] == SatMax || out_tdata[47:32] == SatMin)
    else $error("clip flag without saturated component");

  // A stalled pipeline holds the last divider stage.
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(d_v_r[Steps]) && $stable(d_zq_r[Steps]))
    else $error("divider stage moved during stall");

  // Every entering transaction reaches the divider input through stages 1 to 4 while the pipeline advances.
  a_entry_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_tvalid ##1 en ##1 en ##1 en ##1 en |=> d_v_r[0])
    else $error("transaction lost in front pipeline");
endmodule
